FILE: sv/kbl_pkg.sv
// ----------------------------------------------------------------------------
// kbl_pkg
// Shared types and codes for the keyed bond ledger.
// ----------------------------------------------------------------------------
package kbl_pkg;

  // operation codes
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ADMIT   = 2'd0;
  localparam kind_t KIND_RELEASE = 2'd1;
  localparam kind_t KIND_SLASH   = 2'd2;
  localparam kind_t KIND_FIND    = 2'd3;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t STAT_OK      = 2'd0;
  localparam status_t STAT_INVALID = 2'd1;
  localparam status_t STAT_FULL    = 2'd2;

  // cell load select
  typedef logic [1:0] cell_sel_t;
  localparam cell_sel_t SEL_HOLD = 2'd0;
  localparam cell_sel_t SEL_NEXT = 2'd1;
  localparam cell_sel_t SEL_PREV = 2'd2;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned OCC_W  = 5;

  typedef logic [WORD_W-1:0] word_t;

  // non-key part of one stored bond
  typedef struct packed {
    word_t amount;
    word_t start;
    word_t rel_time;
  } entry_data_t;

  // one result record
  typedef struct packed {
    status_t           status;
    logic              admitted;
    logic              found;
    word_t             entry_amount;
    word_t             entry_start;
    word_t             entry_release;
    word_t             headroom;
    logic [OCC_W-1:0]  occupancy;
    word_t             locked_sum_out;
  } result_t;

endpackage

FILE: sv/kbl_req_if.sv
// ----------------------------------------------------------------------------
// kbl_req_if
// Request channel: valid/ready handshake with the operation payload.
// ----------------------------------------------------------------------------
interface kbl_req_if;
  import kbl_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  word_t act_key;
  word_t bond_amount;
  word_t start_time;
  word_t total_capacity;

  modport source (output valid, output kind, output act_key, output bond_amount,
                  output start_time, output total_capacity, input ready);
  modport sink   (input valid, input kind, input act_key, input bond_amount,
                  input start_time, input total_capacity, output ready);
endinterface

FILE: sv/kbl_rsp_if.sv
// ----------------------------------------------------------------------------
// kbl_rsp_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface kbl_rsp_if;
  import kbl_pkg::*;

  logic             valid;
  logic             ready;
  status_t          status;
  logic             admitted;
  logic             found;
  word_t            entry_amount;
  word_t            entry_start;
  word_t            entry_release;
  word_t            headroom;
  logic [OCC_W-1:0] occupancy;
  word_t            locked_sum_out;

  modport source (output valid, output status, output admitted, output found,
                  output entry_amount, output entry_start, output entry_release,
                  output headroom, output occupancy, output locked_sum_out,
                  input ready);
  modport sink   (input valid, input status, input admitted, input found,
                  input entry_amount, input entry_start, input entry_release,
                  input headroom, input occupancy, input locked_sum_out,
                  output ready);
endinterface

FILE: sv/kbl_cell.sv
// ----------------------------------------------------------------------------
// kbl_cell
// One slot of the bond ring: holds, takes its upper neighbor, or takes its
// lower neighbor.
// ----------------------------------------------------------------------------
module kbl_cell #(
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                  clk,
  input  kbl_pkg::cell_sel_t    sel,
  input  logic [KEY_BITS-1:0]   next_key,
  input  kbl_pkg::entry_data_t  next_data,
  input  logic [KEY_BITS-1:0]   prev_key,
  input  kbl_pkg::entry_data_t  prev_data,
  output logic [KEY_BITS-1:0]   key_q,
  output kbl_pkg::entry_data_t  data_q
);
  import kbl_pkg::*;

  logic [KEY_BITS-1:0] key_r, key_nxt;
  entry_data_t         data_r, data_nxt;

  always_comb begin
    unique case (sel)
      SEL_NEXT: begin
        key_nxt  = next_key;
        data_nxt = next_data;
      end
      SEL_PREV: begin
        key_nxt  = prev_key;
        data_nxt = prev_data;
      end
      default: begin
        key_nxt  = key_r;
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    data_r <= data_nxt;
  end

  assign key_q  = key_r;
  assign data_q = data_r;

endmodule

FILE: sv/keyed_bond_ledger_core.sv
// ----------------------------------------------------------------------------
// keyed_bond_ledger_core
// Fixed-capacity ledger of locked bonds keyed by act identifier.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : one request per handshake (kind, act_key, bond_amount,
//             start_time, total_capacity). Only the low KEY_BITS of act_key
//             are stored and compared.
//   out_rsp : exactly one result per request, in request order.
//   cfg_we / cfg_wdata : writes dispute_window; write only while idle.
// Sequence:
//   After acceptance the ring of cells rotates once past the compare point
//   at cell 0, then an update state inserts, compacts or leaves the ring and
//   loads the result register. The core is ready again the cycle after the
//   update, and it takes no new request while one is in scan or update.
// Reset:
//   rst_n (synchronous, active low) empties the ledger (count and locked sum
//   zero), clears dispute_window and drops any pending result.
// Back-pressure:
//   The result sits in an output register. A new request is accepted while
//   it waits; the next update then holds until the old result is taken.
// ----------------------------------------------------------------------------
module keyed_bond_ledger_core #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  kbl_req_if.sink       in_req,
  kbl_rsp_if.source     out_rsp,
  input  logic          cfg_we,
  input  kbl_pkg::word_t cfg_wdata
);
  import kbl_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  word_t               locked_r, locked_nxt;
  word_t               window_r;
  logic [IDX_W-1:0]    step_r;

  // latched request
  kind_t               kind_r;
  logic [KEY_BITS-1:0] key_r;
  word_t               amount_r;
  word_t               start_r;
  word_t               release_r;
  logic                wrap_r;
  word_t               headroom_r;

  // scan results
  logic                hit_r;
  logic [IDX_W-1:0]    hit_idx_r;
  entry_data_t         hit_data_r;

  // output register
  logic                out_valid_r;
  result_t             res_r, res_nxt;

  // ring of cells
  logic [KEY_BITS-1:0] cell_key  [ENTRIES];
  entry_data_t         cell_data [ENTRIES];
  cell_sel_t           cell_sel  [ENTRIES];
  entry_data_t         new_data;

  logic                accept;
  logic                upd_go;
  logic                do_insert;
  logic                do_remove;
  logic                head_hit;
  logic [WORD_W:0]     rel_sum;

  assign accept   = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == S_IDLE);
  assign upd_go   = (state_r == S_UPDATE) && (!out_valid_r || out_rsp.ready);

  assign rel_sum  = {1'b0, in_req.start_time} + {1'b0, window_r};

  // head cell holds original slot step_r; only occupied slots compare
  assign head_hit = ({{(CNT_W - IDX_W + 1){1'b0}}, step_r} < {1'b0, count_r})
                    && (cell_key[0] == key_r);

  assign new_data = '{amount: amount_r, start: start_r, rel_time: release_r};

  // ---------------- update decision ----------------
  always_comb begin
    res_nxt                = '0;
    res_nxt.headroom       = headroom_r;
    do_insert              = 1'b0;
    do_remove              = 1'b0;
    count_nxt              = count_r;
    locked_nxt             = locked_r;
    if (kind_r == KIND_ADMIT) begin
      if (hit_r || wrap_r) begin
        res_nxt.status = STAT_INVALID;
      end else if (count_r >= FULL_CNT) begin
        res_nxt.status = STAT_FULL;
      end else if (headroom_r >= amount_r) begin
        do_insert        = 1'b1;
        res_nxt.admitted = 1'b1;
        count_nxt        = count_r + CNT_W'(1);
        locked_nxt       = locked_r + amount_r;
      end
    end else if (hit_r) begin
      res_nxt.found = 1'b1;
      if (kind_r == KIND_FIND) begin
        res_nxt.entry_amount  = hit_data_r.amount;
        res_nxt.entry_start   = hit_data_r.start;
        res_nxt.entry_release = hit_data_r.rel_time;
      end else begin
        if (kind_r == KIND_SLASH) begin
          res_nxt.entry_amount = hit_data_r.amount;
        end
        do_remove  = 1'b1;
        count_nxt  = count_r - CNT_W'(1);
        locked_nxt = locked_r - hit_data_r.amount;
      end
    end
    res_nxt.occupancy      = OCC_W'(count_nxt);
    res_nxt.locked_sum_out = locked_nxt;
  end

  // ---------------- cell control ----------------
  // scan: whole ring rotates down one place per cycle
  // insert: ring shifts up, new bond enters at cell 0
  // remove: cells at and above the hit slot shift down (order is immaterial)
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    localparam int unsigned NXT = (i + 1) % ENTRIES;

    always_comb begin
      cell_sel[i] = SEL_HOLD;
      if (state_r == S_SCAN) begin
        cell_sel[i] = SEL_NEXT;
      end else if (upd_go && do_insert) begin
        cell_sel[i] = SEL_PREV;
      end else if (upd_go && do_remove && (IDX_W'(i) >= hit_idx_r)) begin
        cell_sel[i] = SEL_NEXT;
      end
    end

    if (i == 0) begin : g_head
      kbl_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk       (clk),
        .sel       (cell_sel[i]),
        .next_key  (cell_key[NXT]),
        .next_data (cell_data[NXT]),
        .prev_key  (key_r),
        .prev_data (new_data),
        .key_q     (cell_key[i]),
        .data_q    (cell_data[i])
      );
    end else begin : g_body
      kbl_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk       (clk),
        .sel       (cell_sel[i]),
        .next_key  (cell_key[NXT]),
        .next_data (cell_data[NXT]),
        .prev_key  (cell_key[i-1]),
        .prev_data (cell_data[i-1]),
        .key_q     (cell_key[i]),
        .data_q    (cell_data[i])
      );
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_SCAN;
      S_SCAN:   if (step_r == LAST_IDX) state_nxt = S_UPDATE;
      S_UPDATE: if (upd_go) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      locked_r    <= '0;
      window_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      if (upd_go) begin
        count_r     <= count_nxt;
        locked_r    <= locked_nxt;
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r     <= in_req.kind;
      key_r      <= in_req.act_key[KEY_BITS-1:0];
      amount_r   <= in_req.bond_amount;
      start_r    <= in_req.start_time;
      release_r  <= rel_sum[WORD_W-1:0];
      wrap_r     <= rel_sum[WORD_W];
      headroom_r <= (in_req.total_capacity > locked_r) ?
                    (in_req.total_capacity - locked_r) : '0;
      step_r     <= '0;
      hit_r      <= 1'b0;
    end else if (state_r == S_SCAN) begin
      step_r <= step_r + IDX_W'(1);
      if (head_hit) begin
        hit_r      <= 1'b1;
        hit_idx_r  <= step_r;
        hit_data_r <= cell_data[0];
      end
    end
    if (upd_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = res_r.status;
  assign out_rsp.admitted       = res_r.admitted;
  assign out_rsp.found          = res_r.found;
  assign out_rsp.entry_amount   = res_r.entry_amount;
  assign out_rsp.entry_start    = res_r.entry_start;
  assign out_rsp.entry_release  = res_r.entry_release;
  assign out_rsp.headroom       = res_r.headroom;
  assign out_rsp.occupancy      = res_r.occupancy;
  assign out_rsp.locked_sum_out = res_r.locked_sum_out;

  // ---------------- assertions ----------------
  // occupancy never exceeds the ring size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above capacity");

  // an admit never reports a match; a removal never admits
  a_admit_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.admitted && res_r.found))
    else $error("admitted and found both set");

  // entry count changes only on an update
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !upd_go |=> $stable(count_r))
    else $error("entry count changed outside update");

  // an admitted result always carries ok status
  a_admit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.admitted) |-> (res_r.status == STAT_OK))
    else $error("admitted with error status");

endmodule
